### rtl/core/u8dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

	localparam int CP_W          = 21;
	localparam int DW_W          = 2;
	localparam int U8_QUEUE_DEPTH = 2;
	localparam int BUF_SLOTS     = 4;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_MIN_2       = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN_3       = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN_4       = 21'h010000;

	// sequence length implied by a byte used as lead
	localparam logic [2:0] NEED_BAD = 3'd0;
	localparam logic [2:0] NEED_1   = 3'd1;
	localparam logic [2:0] NEED_2   = 3'd2;
	localparam logic [2:0] NEED_3   = 3'd3;
	localparam logic [2:0] NEED_4   = 3'd4;

	localparam logic [DW_W-1:0] WIDTH_ZERO   = 2'd0;
	localparam logic [DW_W-1:0] WIDTH_NORMAL = 2'd1;
	localparam logic [DW_W-1:0] WIDTH_WIDE   = 2'd2;

	// classified byte as it travels from front to back
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] need;
		logic       cont;
	} pkt_t;

	localparam int PKT_W = $bits(pkt_t);

	typedef enum logic [1:0] {
		DEC_EMPTY,
		DEC_WAIT,
		DEC_OK,
		DEC_BAD
	} dec_st_t;

	function automatic logic in_rng(input logic [CP_W-1:0] cp,
			input logic [CP_W-1:0] lo, input logic [CP_W-1:0] hi);
		return (cp >= lo) && (cp <= hi);
	endfunction

	// terminal column width of a code point
	function automatic logic [DW_W-1:0] width_of(input logic [CP_W-1:0] cp);
		logic zero_w;
		logic wide_w;
		zero_w = (cp < 21'h20) || in_rng(cp, 21'h7F, 21'h9F) ||
			in_rng(cp, 21'h0300, 21'h036F);
		wide_w = in_rng(cp, 21'h1100, 21'h115F) || in_rng(cp, 21'h2329, 21'h232A) ||
			in_rng(cp, 21'h2E80, 21'hA4CF) || in_rng(cp, 21'hAC00, 21'hD7A3) ||
			in_rng(cp, 21'hF900, 21'hFAFF) || in_rng(cp, 21'hFE10, 21'hFE19) ||
			in_rng(cp, 21'hFE30, 21'hFE6F) || in_rng(cp, 21'hFF00, 21'hFF60) ||
			in_rng(cp, 21'hFFE0, 21'hFFE6);
		if (zero_w) begin
			return WIDTH_ZERO;
		end else if (wide_w) begin
			return WIDTH_WIDE;
		end
		return WIDTH_NORMAL;
	endfunction

endpackage

`default_nettype wire

### rtl/core/u8dec_if.sv
`timescale 1ns / 1ps
`default_nettype none

// byte channel into the decoder
interface u8dec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

// decoded character channel
interface u8dec_out_if import u8dec_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic [DW_W-1:0] display_width;
	logic            replaced;
	logic            last_of_run;
	modport source (output valid, output code_point, output display_width,
		output replaced, output last_of_run, input ready);
	modport sink (input valid, input code_point, input display_width,
		input replaced, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/core/u8dec_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8dec_front import u8dec_pkg::*; (
	u8dec_in_if.sink in_ch,
	output logic     push_valid,
	output pkt_t     push_pkt,
	input  logic     push_ready
);

	logic [2:0] need;

	// lead length from the top bits of the byte
	always_comb begin
		if (!in_ch.byte_in[7]) begin
			need = NEED_1;
		end else if (in_ch.byte_in[7:5] == 3'b110) begin
			need = NEED_2;
		end else if (in_ch.byte_in[7:4] == 4'b1110) begin
			need = NEED_3;
		end else if (in_ch.byte_in[7:3] == 5'b11110) begin
			need = NEED_4;
		end else begin
			need = NEED_BAD;
		end
	end

	// classified byte goes straight into the queue
	assign push_pkt.data = in_ch.byte_in;
	assign push_pkt.need = need;
	assign push_pkt.cont = (in_ch.byte_in[7:6] == 2'b10);
	assign push_valid    = in_ch.valid;
	assign in_ch.ready   = push_ready;

endmodule

`default_nettype wire

### rtl/core/u8dec_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module u8dec_fifo import u8dec_pkg::*; #(
	parameter int DEPTH = U8_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  pkt_t push_pkt,
	output logic push_ready,
	output logic pop_valid,
	output pkt_t pop_pkt,
	input  logic pop_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pkt_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_pkt    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_pkt;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/u8dec_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8dec_back import u8dec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	input  pkt_t        pop_pkt,
	output logic        pop_ready,
	output logic [2:0]  level,
	u8dec_out_if.source out_ch
);

	localparam int SW = BUF_SLOTS * PKT_W;

	logic [SW-1:0]   slots_q;
	logic [2:0]      cnt_q;
	pkt_t            p0, p1, p2, p3, lead_r;
	logic [SW-1:0]   shifted;
	dec_st_t         st;
	logic            cont_ok;
	logic [CP_W-1:0] v;
	logic [CP_W-1:0] v_min;
	logic [CP_W-1:0] cp;
	logic [2:0]      len;
	logic [2:0]      rem;
	logic            last;
	logic            emit;
	logic            do_pop;

	logic            out_valid_q;
	logic [CP_W-1:0] cp_q;
	logic [DW_W-1:0] width_q;
	logic            rep_q;
	logic            last_q;

	assign p0 = slots_q[0*PKT_W +: PKT_W];
	assign p1 = slots_q[1*PKT_W +: PKT_W];
	assign p2 = slots_q[2*PKT_W +: PKT_W];
	assign p3 = slots_q[3*PKT_W +: PKT_W];

	// assemble the scalar and check continuations for the front lead
	always_comb begin
		case (p0.need)
			NEED_2: begin
				cont_ok = p1.cont;
				v       = {10'b0, p0.data[4:0], p1.data[5:0]};
				v_min   = CP_MIN_2;
			end
			NEED_3: begin
				cont_ok = p1.cont && p2.cont;
				v       = {5'b0, p0.data[3:0], p1.data[5:0], p2.data[5:0]};
				v_min   = CP_MIN_3;
			end
			NEED_4: begin
				cont_ok = p1.cont && p2.cont && p3.cont;
				v       = {p0.data[2:0], p1.data[5:0], p2.data[5:0], p3.data[5:0]};
				v_min   = CP_MIN_4;
			end
			default: begin
				cont_ok = 1'b1;
				v       = {13'b0, p0.data};
				v_min   = '0;
			end
		endcase
	end

	// verdict on the front of the buffer
	always_comb begin
		if (cnt_q == 3'd0) begin
			st = DEC_EMPTY;
		end else if (p0.need == NEED_BAD) begin
			st = DEC_BAD;
		end else if (p0.need > cnt_q) begin
			st = DEC_WAIT;
		end else if (p0.need == NEED_1) begin
			st = DEC_OK;
		end else if (!cont_ok || (v < v_min) || (v > CP_MAX) ||
				((v >= CP_SURR_LO) && (v <= CP_SURR_HI))) begin
			st = DEC_BAD;
		end else begin
			st = DEC_OK;
		end
	end

	// bytes consumed and whether the remainder has to wait for more
	assign len     = (st == DEC_BAD) ? 3'd1 : p0.need;
	assign rem     = cnt_q - len;
	assign shifted = slots_q >> (len * PKT_W);
	assign lead_r  = shifted[0 +: PKT_W];
	assign last    = (rem == 3'd0) || (lead_r.need > rem);
	assign cp      = (st == DEC_BAD) ? CP_REPLACEMENT : v;

	assign emit      = ((st == DEC_OK) || (st == DEC_BAD)) && (!out_valid_q || out_ch.ready);
	assign pop_ready = (st == DEC_EMPTY) || (st == DEC_WAIT);
	assign do_pop    = pop_valid && pop_ready;

	// held bytes: append on pop, drop the consumed front on emit
	always_ff @(posedge clk) begin
		if (emit) begin
			slots_q <= shifted;
		end else if (do_pop) begin
			slots_q[cnt_q[1:0]*PKT_W +: PKT_W] <= pop_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (emit) begin
			cnt_q <= rem;
		end else if (do_pop) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cp_q    <= cp;
			width_q <= width_of(cp);
			rep_q   <= (st == DEC_BAD);
			last_q  <= last;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.code_point    = cp_q;
	assign out_ch.display_width = width_q;
	assign out_ch.replaced      = rep_q;
	assign out_ch.last_of_run   = last_q;
	assign level                = cnt_q;

endmodule

`default_nettype wire

### rtl/core/utf8_stream_decoder_with_width_top.sv
// channel   modport        payload                                            role
// in_ch     sink           byte_in[7:0]                                       raw text bytes
// out_ch    source         code_point[20:0] display_width[1:0] replaced       decoded characters
//                          last_of_run
//
// a byte is classified on entry and queued; the back end moves it
// into its four-byte buffer, then produces characters from the buffer front
// the back end takes no new byte from the queue while a decodable character waits
// at the buffer front; a rejected byte yields one replacement character
// the buffer-to-output step (one decode and shift per cycle if unstalled) sets the pace
// reset clears queue pointers, buffer fill and output valid; held bytes need no clearing
// the queue keeps accepting while the output register is stalled, until it is full
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_with_width_top import u8dec_pkg::*; #(
	parameter int QUEUE_DEPTH = U8_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	u8dec_in_if.sink    in_ch,
	u8dec_out_if.source out_ch
);

	logic       push_valid;
	pkt_t       push_pkt;
	logic       push_ready;
	logic       pop_valid;
	pkt_t       pop_pkt;
	logic       pop_ready;
	logic [2:0] level;

	// classify incoming bytes
	u8dec_front u_front (
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_pkt   (push_pkt),
		.push_ready (push_ready)
	);

	// queue between front and back
	u8dec_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_pkt   (push_pkt),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_pkt    (pop_pkt),
		.pop_ready  (pop_ready)
	);

	// decode and emit characters
	u8dec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_pkt   (pop_pkt),
		.pop_ready (pop_ready),
		.level     (level),
		.out_ch    (out_ch)
	);

	// a queued transaction is visible to the back end on the next cycle
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready) |=> pop_valid)
		else $error("queue lost a byte");

	// a replacement always carries U+FFFD at width one
	a_replaced_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.replaced) |->
		(out_ch.code_point == CP_REPLACEMENT) && (out_ch.display_width == WIDTH_NORMAL))
		else $error("bad replacement character");

	// a result that is not the last of its byte leaves bytes in the buffer
	a_not_last_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.last_of_run) |-> (level != 3'd0))
		else $error("run ended without last flag");

	// the buffer never holds more than four bytes
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'd4)
		else $error("buffer overfilled");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top import u8dec_pkg::*; ();

	// outcome of decoding at the front of the held bytes
	localparam int FRONT_SHORT = 0;
	localparam int FRONT_BAD   = -1;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [DW_W-1:0] cols;
		logic            rep;
		logic            last;
	} char_t;

	logic clk = 1'b0;
	logic arst_n;

	u8dec_in_if  in_ch ();
	u8dec_out_if out_ch ();

	utf8_stream_decoder_with_width_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// decoder shadow state and pending characters
	char_t      char_q[$];
	char_t      want_c;
	logic [7:0] held [3];
	int         held_n;
	logic [7:0] work [4];
	int         work_n;
	logic [7:0] bytes_q[$];
	int         sent_n;
	int         errors;
	bit         no_idle;

	// clock
	always #1 clk = ~clk;

	// watchdog
	initial begin
		#200000;
		$display("tb_top: errors");
		$finish;
	end

	// random backpressure on the character channel
	always @(posedge clk) begin
		out_ch.ready <= no_idle || ($urandom_range(99) >= 9);
	end

	function automatic bit between(input logic [CP_W-1:0] cp, input logic [CP_W-1:0] lo,
			input logic [CP_W-1:0] hi);
		return cp >= lo && cp <= hi;
	endfunction

	// terminal columns taken by a code point
	function automatic logic [DW_W-1:0] col_width(input logic [CP_W-1:0] cp);
		if (cp < 'h20 || between(cp, 'h7F, 'h9F) || between(cp, 'h300, 'h36F)) begin
			return WIDTH_ZERO;
		end
		if (between(cp, 'h1100, 'h115F) || between(cp, 'h2329, 'h232A) ||
				between(cp, 'h2E80, 'hA4CF) || between(cp, 'hAC00, 'hD7A3) ||
				between(cp, 'hF900, 'hFAFF) || between(cp, 'hFE10, 'hFE19) ||
				between(cp, 'hFE30, 'hFE6F) || between(cp, 'hFF00, 'hFF60) ||
				between(cp, 'hFFE0, 'hFFE6)) begin
			return WIDTH_WIDE;
		end
		return WIDTH_NORMAL;
	endfunction

	// decode one sequence starting at work[at]
	function automatic int front_len(input int at, output logic [CP_W-1:0] cp);
		logic [7:0]      lead;
		logic [CP_W-1:0] v;
		logic [CP_W-1:0] lo;
		int              need;
		int              i;
		lead = work[at];
		cp = '0;
		v = '0;
		if (!lead[7]) begin
			cp = {13'd0, lead};
			return 1;
		end
		if (lead[7:5] == 3'b110) begin
			need = 2;
			v = {16'd0, lead[4:0]};
			lo = CP_MIN_2;
		end else if (lead[7:4] == 4'b1110) begin
			need = 3;
			v = {17'd0, lead[3:0]};
			lo = CP_MIN_3;
		end else if (lead[7:3] == 5'b11110) begin
			need = 4;
			v = {18'd0, lead[2:0]};
			lo = CP_MIN_4;
		end else begin
			return FRONT_BAD;
		end
		// a short sequence waits, whatever its tail looks like
		if (work_n - at < need) begin
			return FRONT_SHORT;
		end
		for (i = 1; i < need; i++) begin
			if (work[at+i][7:6] != 2'b10) begin
				return FRONT_BAD;
			end
			v = {v[CP_W-7:0], work[at+i][5:0]};
		end
		if (v < lo || v > CP_MAX || between(v, CP_SURR_LO, CP_SURR_HI)) begin
			return FRONT_BAD;
		end
		cp = v;
		return need;
	endfunction

	// expected characters for one accepted byte
	function automatic void decode_byte(input logic [7:0] b);
		logic [CP_W-1:0] cp;
		char_t           c;
		char_t           prev;
		bit              have;
		bit              stop;
		int              pos;
		int              r;
		int              k;
		int              i;
		for (i = 0; i < held_n; i++) begin
			work[i] = held[i];
		end
		work[held_n] = b;
		work_n = held_n + 1;
		pos = 0;
		k = 0;
		have = 0;
		stop = 0;
		prev = '0;
		while (!stop && pos < work_n && k < 4) begin
			r = front_len(pos, cp);
			if (r == FRONT_SHORT) begin
				stop = 1;
			end else begin
				c = '0;
				if (r == FRONT_BAD) begin
					cp = CP_REPLACEMENT;
					c.rep = 1'b1;
					pos++;
				end else begin
					pos += r;
				end
				c.cp = cp;
				c.cols = col_width(cp);
				if (have) begin
					char_q.push_back(prev);
				end
				prev = c;
				have = 1;
				k++;
			end
		end
		if (have) begin
			prev.last = 1'b1;
			char_q.push_back(prev);
		end
		// leftover bytes stay held
		held_n = 0;
		while (pos < work_n && held_n < 3) begin
			held[held_n] = work[pos];
			held_n++;
			pos++;
		end
	endfunction

	// check each accepted character against the oldest pending one
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (char_q.size() == 0) begin
				errors++;
				$display("%0t: expected no character, actual cp %h", $time, out_ch.code_point);
			end else begin
				want_c = char_q.pop_front();
				if (out_ch.code_point !== want_c.cp) begin
					errors++;
					$display("%0t: code_point expected %h actual %h", $time, want_c.cp,
						out_ch.code_point);
				end
				if (out_ch.display_width !== want_c.cols) begin
					errors++;
					$display("%0t: display_width expected %0d actual %0d (cp %h)", $time,
						want_c.cols, out_ch.display_width, want_c.cp);
				end
				if (out_ch.replaced !== want_c.rep) begin
					errors++;
					$display("%0t: replaced expected %b actual %b (cp %h)", $time,
						want_c.rep, out_ch.replaced, want_c.cp);
				end
				if (out_ch.last_of_run !== want_c.last) begin
					errors++;
					$display("%0t: last_of_run expected %b actual %b (cp %h)", $time,
						want_c.last, out_ch.last_of_run, want_c.cp);
				end
			end
		end
	end

	// one byte transaction, with random gaps before it
	task automatic send_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(99) < 9) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.byte_in <= b;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		decode_byte(b);
		sent_n++;
	endtask

	task automatic send_queue();
		while (bytes_q.size() != 0) begin
			send_byte(bytes_q.pop_front());
		end
	endtask

	// encode cp in exactly len bytes, overlong or out of range if asked
	function automatic void encode(input logic [CP_W-1:0] cp, input int len);
		case (len)
			1: bytes_q.push_back(cp[7:0]);
			2: begin
				bytes_q.push_back({3'b110, cp[10:6]});
				bytes_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				bytes_q.push_back({4'b1110, cp[15:12]});
				bytes_q.push_back({2'b10, cp[11:6]});
				bytes_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				bytes_q.push_back({5'b11110, cp[20:18]});
				bytes_q.push_back({2'b10, cp[17:12]});
				bytes_q.push_back({2'b10, cp[11:6]});
				bytes_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic int natural_len(input logic [CP_W-1:0] cp);
		if (cp < 'h80) begin
			return 1;
		end else if (cp < 'h800) begin
			return 2;
		end else if (cp < 'h10000) begin
			return 3;
		end
		return 4;
	endfunction

	// code points at the edges of the width classes and lengths
	function automatic logic [CP_W-1:0] width_bound(input int idx);
		case (idx)
			0:  return 'h1F;
			1:  return 'h7F;
			2:  return 'h9F;
			3:  return 'hA0;
			4:  return 'h300;
			5:  return 'h36F;
			6:  return 'h7FF;
			7:  return 'h800;
			8:  return 'h1100;
			9:  return 'h115F;
			10: return 'h2329;
			11: return 'h232A;
			12: return 'h2E80;
			13: return 'hA4CF;
			14: return 'hAC00;
			15: return 'hD7A3;
			16: return 'hF900;
			17: return 'hFAFF;
			18: return 'hFE10;
			19: return 'hFE19;
			20: return 'hFE30;
			21: return 'hFE6F;
			22: return 'hFF00;
			23: return 'hFF60;
			24: return 'hFFE0;
			25: return 'hFFE6;
			26: return 'hFFFD;
			27: return 'h10000;
			default: return 'h10FFFF;
		endcase
	endfunction

	function automatic logic [CP_W-1:0] pick_cp();
		logic [CP_W-1:0] v;
		case ($urandom_range(5))
			0: v = CP_W'($urandom_range('h7F));
			1: v = CP_W'($urandom_range('h7FF, 'h80));
			2: v = CP_W'(width_bound($urandom_range(28)) + $urandom_range(2) - 1);
			3: begin
				v = CP_W'($urandom_range('hFFFF, 'h800));
				if (between(v, CP_SURR_LO, CP_SURR_HI)) begin
					v = v ^ CP_W'('h1000);
				end
			end
			4: v = CP_W'($urandom_range('h10FFFF, 'h10000));
			default: v = CP_W'($urandom_range('h9FFF, 'h4E00));
		endcase
		return v;
	endfunction

	task automatic send_char(input logic [CP_W-1:0] cp);
		encode(cp, natural_len(cp));
		send_queue();
	endtask

	// malformed input: noise, cut or damaged sequences, overlong, surrogate, too large
	task automatic send_broken();
		logic [CP_W-1:0] cp;
		int              len;
		int              cut;
		case ($urandom_range(5))
			0: bytes_q.push_back(8'($urandom_range(255)));
			1: begin
				cp = CP_W'($urandom_range('h10FFFF, 'h800));
				len = natural_len(cp);
				encode(cp, len);
				cut = $urandom_range(len - 1, 1);
				repeat (cut) void'(bytes_q.pop_back());
			end
			2: begin
				cp = CP_W'($urandom_range('h10FFFF, 'h80));
				encode(cp, natural_len(cp));
				bytes_q[$urandom_range(bytes_q.size() - 1, 1)] = 8'($urandom_range(255));
			end
			3: begin
				len = $urandom_range(4, 2);
				cp = CP_W'($urandom_range(len == 2 ? 'h7F : (len == 3 ? 'h7FF : 'hFFFF)));
				encode(cp, len);
			end
			4: encode(CP_W'($urandom_range('hDFFF, 'hD800)), 3);
			default: encode(CP_W'($urandom_range('h1FFFFF, 'h110000)), 4);
		endcase
		send_queue();
	endtask

	task automatic wait_all_chars();
		in_ch.valid <= 1'b0;
		while (char_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// field extremes, rejected leads, overlong, surrogate, max, out of range, short wait
	task automatic test_directed();
		bytes_q = '{8'h00, 8'h1B, 8'h7F, 8'h80, 8'hFF,
			8'hC1, 8'hBF,
			8'hE4, 8'hB8, 8'hAD,
			8'hED, 8'hA0, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF,
			8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'hF0, 8'h41, 8'h42, 8'h43};
		send_queue();
	endtask

	// mostly well-formed text with random gaps on both sides
	task automatic test_random_text();
		int target;
		target = sent_n + 75;
		while (sent_n < target) begin
			if ($urandom_range(99) < 85) begin
				send_char(pick_cp());
			end else begin
				send_broken();
			end
		end
	endtask

	// long stretch at full rate, then hold off until everything is out
	task automatic test_back_to_back();
		int target;
		target = sent_n + 60;
		no_idle = 1;
		while (sent_n < target) begin
			if ($urandom_range(99) < 80) begin
				send_char(pick_cp());
			end else begin
				send_broken();
			end
		end
		wait_all_chars();
		no_idle = 0;
	endtask

	// error-heavy stream mixed with valid characters
	task automatic test_broken_sequences();
		int target;
		target = sent_n + 50;
		while (sent_n < target) begin
			if ($urandom_range(1) == 0) begin
				send_char(pick_cp());
			end else begin
				send_broken();
			end
		end
	endtask

	// main sequence
	initial begin
		in_ch.valid = 1'b0;
		in_ch.byte_in = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		no_idle = 0;
		held_n = 0;
		sent_n = 0;
		errors = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_text();
		test_back_to_back();
		test_broken_sequences();
		wait_all_chars();
		repeat (20) @(posedge clk);
		if (errors == 0 && char_q.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
